/* hw/rtl/block_average_ascii_quantizer_macros.svh */
// Assertion helpers shared by the quantizer RTL.
// Both expect clk_i and rst_ni in the enclosing scope.
`ifndef BLOCK_AVERAGE_ASCII_QUANTIZER_MACROS_SVH
`define BLOCK_AVERAGE_ASCII_QUANTIZER_MACROS_SVH

// Same-cycle implication.
`define BAVQ_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bavq assertion failed");

// Next-cycle implication.
`define BAVQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bavq assertion failed");

`endif

/* hw/rtl/bavq_pkg.sv */
package bavq_pkg;

  localparam int unsigned MAX_COLS_DEF   = 1024;
  localparam int unsigned MAX_WINDOW_DEF = 3;

  localparam int unsigned PIX_W       = 8;
  localparam int unsigned TOTAL_W     = 12;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned COLS_W      = 11;
  localparam int unsigned WIN_W       = 2;
  localparam int unsigned CMP_W       = 13;
  localparam int unsigned COUNT_W     = 4;
  localparam int unsigned LEVEL_W     = 4;
  localparam int unsigned SYM_W       = 7;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned RECIP_W     = 17;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned PROD_W      = TOTAL_W + RECIP_W;
  localparam int unsigned BAND_N      = 9;

  localparam logic [PIX_W-1:0] BAND_TOP [BAND_N] = '{
    8'd25, 8'd51, 8'd77, 8'd103, 8'd129, 8'd155, 8'd181, 8'd207, 8'd233
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_ROWS   = 2'd1,
    CFG_COLS   = 2'd2
  } bavq_cfg_e;

  // Per-pixel window bookkeeping, produced at accept time.
  typedef struct packed {
    logic               h_end;
    logic               v_end;
    logic               use_col;
    logic               row_end;
    logic               frame_end;
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] row_sum;
  } bavq_win_t;

  // Finished window sum headed for the divider.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic [COUNT_W-1:0] count;
    logic               row_end;
    logic               frame_end;
  } bavq_res_t;

  // ceil(2^16 / d): exact floor division for totals below 4096, d in 1..9.
  function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21846;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13108;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9363;
      4'd8:    r = 17'd8192;
      4'd9:    r = 17'd7282;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [LEVEL_W-1:0] band_level(input logic [TOTAL_W-1:0] avg);
    logic [LEVEL_W-1:0] lvl;
    lvl = '0;
    for (int i = 0; i < BAND_N; i++) begin
      if (avg > {{(TOTAL_W-PIX_W){1'b0}}, BAND_TOP[i]}) begin
        lvl = lvl + 4'd1;
      end
    end
    return lvl;
  endfunction

  function automatic logic [SYM_W-1:0] band_symbol(input logic [LEVEL_W-1:0] lvl);
    logic [SYM_W-1:0] s;
    case (lvl)
      4'd0:    s = 7'h23;  // '#'
      4'd1:    s = 7'h40;  // '@'
      4'd2:    s = 7'h25;  // '%'
      4'd3:    s = 7'h2B;  // '+'
      4'd4:    s = 7'h2A;  // '*'
      4'd5:    s = 7'h3D;  // '='
      4'd6:    s = 7'h3A;  // ':'
      4'd7:    s = 7'h2D;  // '-'
      4'd8:    s = 7'h2E;  // '.'
      default: s = 7'h20;  // space
    endcase
    return s;
  endfunction

endpackage

/* hw/rtl/bavq_ram.sv */
module bavq_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read-first: a read of the entry being written returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/bavq_track.sv */
module bavq_track #(
  parameter int unsigned MAX_COLS = bavq_pkg::MAX_COLS_DEF,
  localparam int unsigned COL_W   = $clog2(MAX_COLS)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  logic                          restart_i,
  input  logic [bavq_pkg::PIX_W-1:0]    pixel_i,
  input  logic [bavq_pkg::WIN_W-1:0]    win_size_i,
  input  logic [bavq_pkg::ROW_W-1:0]    rows_i,
  input  logic [bavq_pkg::CMP_W-1:0]    cols_i,
  output bavq_pkg::bavq_win_t           win_o,
  output logic [COL_W-1:0]              oc_o
);
  import bavq_pkg::*;

  logic [TOTAL_W-1:0] row_sum_q, row_sum_d;
  logic [ROW_W-1:0]   row_pos_q, row_pos_d;
  logic [COL_W-1:0]   col_pos_q, col_pos_d;
  logic [COL_W-1:0]   oc_q, oc_d;
  logic [WIN_W-1:0]   riw_q, riw_d;
  logic [WIN_W-1:0]   ciw_q, ciw_d;

  logic               last_col, last_row, h_end, v_end;
  logic [WIN_W-1:0]   ciw_inc, riw_inc;
  logic [TOTAL_W-1:0] sum;

  always_comb begin
    last_col = (CMP_W'(col_pos_q) + CMP_W'(1)) >= cols_i;
    last_row = (CMP_W'(row_pos_q) + CMP_W'(1)) >= CMP_W'(rows_i);
    ciw_inc  = ciw_q + WIN_W'(1);
    riw_inc  = riw_q + WIN_W'(1);
    h_end    = last_col || (ciw_inc >= win_size_i);
    v_end    = last_row || (riw_inc >= win_size_i);
    sum      = row_sum_q + TOTAL_W'(pixel_i);

    win_o.h_end     = h_end;
    win_o.v_end     = v_end;
    win_o.use_col   = (riw_q != '0);
    win_o.row_end   = last_col;
    win_o.frame_end = last_col && last_row;
    win_o.count     = ({2'b00, riw_q} + 4'd1) * ({2'b00, ciw_q} + 4'd1);
    win_o.row_sum   = sum;
  end

  assign oc_o = oc_q;

  always_comb begin
    row_sum_d = row_sum_q;
    row_pos_d = row_pos_q;
    col_pos_d = col_pos_q;
    oc_d      = oc_q;
    riw_d     = riw_q;
    ciw_d     = ciw_q;
    if (restart_i) begin
      row_sum_d = '0;
      row_pos_d = '0;
      col_pos_d = '0;
      oc_d      = '0;
      riw_d     = '0;
      ciw_d     = '0;
    end else if (accept_i) begin
      row_sum_d = h_end ? '0 : sum;
      if (last_col) begin
        col_pos_d = '0;
        oc_d      = '0;
        ciw_d     = '0;
        if (last_row) begin
          row_pos_d = '0;
          riw_d     = '0;
        end else begin
          row_pos_d = row_pos_q + ROW_W'(1);
          riw_d     = (riw_inc >= win_size_i) ? '0 : riw_inc;
        end
      end else begin
        col_pos_d = col_pos_q + COL_W'(1);
        ciw_d     = (ciw_inc >= win_size_i) ? '0 : ciw_inc;
        // advance to the next output column once a window closes
        if (h_end) begin
          oc_d = oc_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_sum_q <= '0;
      row_pos_q <= '0;
      col_pos_q <= '0;
      oc_q      <= '0;
      riw_q     <= '0;
      ciw_q     <= '0;
    end else begin
      row_sum_q <= row_sum_d;
      row_pos_q <= row_pos_d;
      col_pos_q <= col_pos_d;
      oc_q      <= oc_d;
      riw_q     <= riw_d;
      ciw_q     <= ciw_d;
    end
  end

endmodule

/* hw/rtl/bavq_quant.sv */
module bavq_quant (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  bavq_pkg::bavq_res_t          in_res_i,
  input  logic                         out_ready_i,
  output logic                         adv_o,
  output logic                         out_valid_o,
  output logic [bavq_pkg::SYM_W-1:0]   symbol_o,
  output logic [bavq_pkg::LEVEL_W-1:0] level_o,
  output logic                         row_end_o,
  output logic                         frame_end_o
);
  import bavq_pkg::*;

  logic               adv;
  logic               s2_valid_q, s3_valid_q, out_valid_q;
  bavq_res_t          s2_q;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic               s3_row_end_q, s3_frame_end_q;
  logic [TOTAL_W-1:0] avg;
  logic [LEVEL_W-1:0] level_d, level_q;
  logic [SYM_W-1:0]   symbol_q;
  logic               row_end_q, frame_end_q;

  // The whole pipe moves only when the output register can take a transaction.
  assign adv   = !out_valid_q || out_ready_i;
  assign adv_o = adv;

  assign prod_d  = {{RECIP_W{1'b0}}, s2_q.total} *
                   {{TOTAL_W{1'b0}}, recip(s2_q.count)};
  assign avg     = prod_q[RECIP_SHIFT +: TOTAL_W];
  assign level_d = band_level(avg);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q  <= in_valid_i;
      s3_valid_q  <= s2_valid_q;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_q           <= in_res_i;
      prod_q         <= prod_d;
      s3_row_end_q   <= s2_q.row_end;
      s3_frame_end_q <= s2_q.frame_end;
      level_q        <= level_d;
      symbol_q       <= band_symbol(level_d);
      row_end_q      <= s3_row_end_q;
      frame_end_q    <= s3_frame_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign symbol_o    = symbol_q;
  assign level_o     = level_q;
  assign row_end_o   = row_end_q;
  assign frame_end_o = frame_end_q;

endmodule

/* hw/rtl/block_average_ascii_quantizer.sv */
// Block-average ASCII quantizer. Takes one 8-bit pixel per cycle in raster order and
// emits one character per closed window; with the output side always ready it sustains
// one pixel per clock; the pixel that closes a window yields its character through the s1,
// s2, product and output registers. The rate is set by the column-sum line memory, which
// is read once and written at most once per pixel (one read port, one write port); a pixel
// accepted on the edge at which the transaction ahead writes the same column gets that sum
// forwarded. Division by the window's pixel count (1 to 9) is a reciprocal multiply, one
// stage, followed by a band-compare stage. A stalled output register stalls the whole pipe.
// Any configuration write restarts the frame; line memory contents are kept and need no
// clearing, since every entry is written on the first row of its window before use.
`include "block_average_ascii_quantizer_macros.svh"

module block_average_ascii_quantizer #(
  parameter int unsigned MAX_COLS   = bavq_pkg::MAX_COLS_DEF,
  parameter int unsigned MAX_WINDOW = bavq_pkg::MAX_WINDOW_DEF,
  localparam int unsigned COL_W     = $clog2(MAX_COLS)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bavq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bavq_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [bavq_pkg::PIX_W-1:0]      pixel_value_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [bavq_pkg::SYM_W-1:0]      symbol_o,
  output logic [bavq_pkg::LEVEL_W-1:0]    level_o,
  output logic                            row_end_o,
  output logic                            frame_end_o
);
  import bavq_pkg::*;

  logic [WIN_W-1:0]  window_size_q, window_size_d;
  logic [ROW_W-1:0]  image_rows_q, image_rows_d;
  logic [COLS_W-1:0] image_cols_q, image_cols_d;

  logic [WIN_W-1:0]  ws_eff;
  logic [ROW_W-1:0]  rows_eff;
  logic [CMP_W-1:0]  cols_eff;

  logic              adv, accept;
  bavq_win_t         trk_win;
  logic [COL_W-1:0]  trk_oc;

  logic              s1_valid_q, s1_valid_d;
  bavq_win_t         s1_q;
  logic [COL_W-1:0]  s1_oc_q;
  logic              fwd_q, fwd_d;
  logic [TOTAL_W-1:0] fwd_data_q;

  logic [TOTAL_W-1:0] ram_rdata, col_sum, total;
  logic               ram_we;
  bavq_res_t          res;
  logic               res_valid;

  // Configuration
  always_comb begin
    window_size_d = window_size_q;
    image_rows_d  = image_rows_q;
    image_cols_d  = image_cols_q;
    if (cfg_we_i) begin
      case (bavq_cfg_e'(cfg_idx_i))
        CFG_WINDOW: window_size_d = cfg_wdata_i[WIN_W-1:0];
        CFG_ROWS:   image_rows_d  = cfg_wdata_i[ROW_W-1:0];
        CFG_COLS:   image_cols_d  = cfg_wdata_i[COLS_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WIN_W'(1);
      image_rows_q  <= ROW_W'(1);
      image_cols_q  <= COLS_W'(1);
    end else begin
      window_size_q <= window_size_d;
      image_rows_q  <= image_rows_d;
      image_cols_q  <= image_cols_d;
    end
  end

  always_comb begin
    if (window_size_q == '0) begin
      ws_eff = WIN_W'(1);
    end else if (window_size_q > WIN_W'(MAX_WINDOW)) begin
      ws_eff = WIN_W'(MAX_WINDOW);
    end else begin
      ws_eff = window_size_q;
    end
    rows_eff = (image_rows_q == '0) ? ROW_W'(1) : image_rows_q;
    if (image_cols_q == '0) begin
      cols_eff = CMP_W'(1);
    end else if (CMP_W'(image_cols_q) > CMP_W'(MAX_COLS)) begin
      cols_eff = CMP_W'(MAX_COLS);
    end else begin
      cols_eff = CMP_W'(image_cols_q);
    end
  end

  // Position tracking
  assign accept     = in_valid_i && adv;
  assign in_ready_o = adv;

  bavq_track #(
    .MAX_COLS (MAX_COLS)
  ) u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .restart_i  (cfg_we_i),
    .pixel_i    (pixel_value_i),
    .win_size_i (ws_eff),
    .rows_i     (rows_eff),
    .cols_i     (cols_eff),
    .win_o      (trk_win),
    .oc_o       (trk_oc)
  );

  // Stage 1: line memory read-modify-write.
  // Forward when the transaction ahead writes the column being read on the same edge.
  assign fwd_d      = s1_valid_q && s1_q.h_end && (s1_oc_q == trk_oc);
  assign s1_valid_d = adv ? accept : s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept) begin
        fwd_q <= fwd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q    <= trk_win;
      s1_oc_q <= trk_oc;
    end
    if (ram_we) begin
      fwd_data_q <= total;
    end
  end

  bavq_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (MAX_COLS)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_oc_q),
    .wdata_i (total),
    .re_i    (accept),
    .raddr_i (trk_oc),
    .rdata_o (ram_rdata)
  );

  assign col_sum = fwd_q ? fwd_data_q : ram_rdata;
  assign total   = s1_q.row_sum + (s1_q.use_col ? col_sum : '0);
  assign ram_we  = adv && s1_valid_q && s1_q.h_end;

  assign res_valid     = s1_valid_q && s1_q.h_end && s1_q.v_end;
  assign res.total     = total;
  assign res.count     = s1_q.count;
  assign res.row_end   = s1_q.row_end;
  assign res.frame_end = s1_q.frame_end;

  // Divide and quantize
  bavq_quant u_quant (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (res_valid),
    .in_res_i    (res),
    .out_ready_i (out_ready_i),
    .adv_o       (adv),
    .out_valid_o (out_valid_o),
    .symbol_o    (symbol_o),
    .level_o     (level_o),
    .row_end_o   (row_end_o),
    .frame_end_o (frame_end_o)
  );

  `BAVQ_ASSERT_IMPL(a_frame_end_closes, s1_valid_q && s1_q.frame_end, s1_q.h_end && s1_q.v_end)
  `BAVQ_ASSERT_IMPL(a_count_range, s1_valid_q && s1_q.h_end, (s1_q.count != '0) && (s1_q.count <= 4'd9))
  `BAVQ_ASSERT_NEXT(a_stall_holds_s1, s1_valid_q && !in_ready_o, s1_valid_q)
  `BAVQ_ASSERT_IMPL(a_frame_end_row_end, out_valid_o && frame_end_o, row_end_o)

endmodule

/* bench/block_average_ascii_quantizer_test.sv */
`timescale 1ns / 1ps

module block_average_ascii_quantizer_test;
  import bavq_pkg::*;

  localparam int unsigned ITEM_TARGET   = 1650;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int unsigned LEVEL_COUNT   = 10;

  // Index past the last register: ignored by the block, but still restarts the frame.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // Upper edge of each brightness band, darkest first.
  localparam int unsigned BAND_LIMIT [9] = '{25, 51, 77, 103, 129, 155, 181, 207, 233};
  // '#' '@' '%' '+' '*' '=' ':' '-' '.' ' '
  localparam logic [SYM_W-1:0] GLYPH [LEVEL_COUNT] = '{
    7'h23, 7'h40, 7'h25, 7'h2B, 7'h2A, 7'h3D, 7'h3A, 7'h2D, 7'h2E, 7'h20
  };

  typedef struct packed {
    logic [SYM_W-1:0]   symbol;
    logic [LEVEL_W-1:0] level;
    logic               row_end;
    logic               frame_end;
  } glyph_t;

  class quantizer_scoreboard;
    logic [TOTAL_W-1:0] col_sum [MAX_COLS_DEF];
    logic [TOTAL_W-1:0] row_acc;
    int unsigned        row_pos;
    int unsigned        col_pos;
    int unsigned        row_off;
    int unsigned        col_off;
    logic [WIN_W-1:0]   win_reg;
    logic [ROW_W-1:0]   rows_reg;
    logic [COLS_W-1:0]  cols_reg;
    glyph_t             awaited [$];
    int unsigned        errors;
    int unsigned        pixels;
    int unsigned        checked;
    int unsigned        frames;
    int unsigned        writes;
    logic [LEVEL_COUNT-1:0] levels_seen;

    function new();
      win_reg     = WIN_W'(1);
      rows_reg    = ROW_W'(1);
      cols_reg    = COLS_W'(1);
      errors      = 0;
      pixels      = 0;
      checked     = 0;
      frames      = 0;
      writes      = 0;
      levels_seen = '0;
      restart();
    endfunction

    function void restart();
      row_acc = '0;
      row_pos = 0;
      col_pos = 0;
      row_off = 0;
      col_off = 0;
    endfunction

    function int unsigned eff_window();
      if (win_reg == 0) return 1;
      if (32'(win_reg) > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
      return 32'(win_reg);
    endfunction

    function int unsigned eff_rows();
      return (rows_reg == 0) ? 1 : 32'(rows_reg);
    endfunction

    function int unsigned eff_cols();
      if (cols_reg == 0) return 1;
      if (32'(cols_reg) > MAX_COLS_DEF) return MAX_COLS_DEF;
      return 32'(cols_reg);
    endfunction

    function int unsigned frame_pixels();
      return eff_rows() * eff_cols();
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_WINDOW: win_reg  = data[WIN_W-1:0];
        CFG_ROWS:   rows_reg = data[ROW_W-1:0];
        CFG_COLS:   cols_reg = data[COLS_W-1:0];
        default: ;
      endcase
      writes++;
      restart();
    endfunction

    function void note_pixel(logic [PIX_W-1:0] pix);
      int unsigned        ws;
      int unsigned        oc;
      int unsigned        cnt;
      int unsigned        avg;
      int unsigned        lvl;
      bit                 last_col;
      bit                 last_row;
      logic [TOTAL_W-1:0] total;
      glyph_t             g;
      ws       = eff_window();
      last_col = (col_pos + 1 >= eff_cols());
      last_row = (row_pos + 1 >= eff_rows());
      pixels++;
      row_acc = row_acc + TOTAL_W'(pix);
      if (last_col || col_off + 1 >= ws) begin
        oc    = (col_pos / ws) % MAX_COLS_DEF;
        total = row_acc;
        // First row of a window starts the column sum afresh.
        if (row_off != 0) total = total + col_sum[oc];
        col_sum[oc] = total;
        row_acc     = '0;
        if (last_row || row_off + 1 >= ws) begin
          cnt = (row_off + 1) * (col_off + 1);
          avg = 32'(total) / cnt;
          lvl = 0;
          while (lvl < 9 && avg > BAND_LIMIT[lvl]) lvl++;
          g.symbol    = GLYPH[lvl];
          g.level     = LEVEL_W'(lvl);
          g.row_end   = last_col;
          g.frame_end = last_col && last_row;
          awaited.push_back(g);
        end
      end
      if (last_col) begin
        col_pos = 0;
        col_off = 0;
        if (last_row) begin
          row_pos = 0;
          row_off = 0;
        end else begin
          row_pos++;
          row_off = (row_off + 1 >= ws) ? 0 : row_off + 1;
        end
      end else begin
        col_pos++;
        col_off = (col_off + 1 >= ws) ? 0 : col_off + 1;
      end
    endfunction

    function void check_glyph(glyph_t got);
      glyph_t want;
      checked++;
      if (got.frame_end === 1'b1) frames++;
      if (got.level <= LEVEL_W'(LEVEL_COUNT - 1)) levels_seen[got.level] = 1'b1;
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("unexpected character: symbol %h level %0d row_end %b frame_end %b",
                   got.symbol, got.level, got.row_end, got.frame_end);
        end
        return;
      end
      want = awaited.pop_front();
      if (got.symbol !== want.symbol || got.level !== want.level ||
          got.row_end !== want.row_end || got.frame_end !== want.frame_end) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("mismatch on character %0d: expected symbol %h level %0d row_end %b frame_end %b, got symbol %h level %0d row_end %b frame_end %b",
                   checked, want.symbol, want.level, want.row_end, want.frame_end,
                   got.symbol, got.level, got.row_end, got.frame_end);
        end
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [PIX_W-1:0]      pixel_value_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [SYM_W-1:0]      symbol_o;
  logic [LEVEL_W-1:0]    level_o;
  logic                  row_end_o;
  logic                  frame_end_o;

  quantizer_scoreboard board = new();
  bit squeeze = 1'b0;

  block_average_ascii_quantizer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .pixel_value_i (pixel_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .symbol_o      (symbol_o),
    .level_o       (level_o),
    .row_end_o     (row_end_o),
    .frame_end_o   (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic send_pixel(input logic [PIX_W-1:0] pix);
    in_valid_i    <= 1'b1;
    pixel_value_i <= pix;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.note_pixel(pix);
  endtask

  // Offer n pixels in bursts; mode 0 random, 1 flat, 2 flat with a toggling low bit.
  task automatic send_run(input int unsigned n, input int unsigned mode);
    int unsigned      left;
    int unsigned      burst;
    logic [PIX_W-1:0] flat;
    logic [PIX_W-1:0] pix;
    case ($urandom_range(0, 3))
      0:       flat = '0;
      1:       flat = '1;
      default: flat = PIX_W'(BAND_LIMIT[$urandom_range(0, 8)] + $urandom_range(0, 1));
    endcase
    left = n;
    while (left != 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      repeat (burst) begin
        case (mode)
          0:       pix = PIX_W'($urandom);
          1:       pix = flat;
          default: pix = flat ^ PIX_W'($urandom_range(0, 1));
        endcase
        send_pixel(pix);
      end
      left -= burst;
      if (left != 0 && $urandom_range(0, 2) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  // Drain, then let pixels that close no window clear the pipe.
  task automatic settle();
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    board.configure(idx, data);
  endtask

  task automatic apply_settings(input logic [CFG_DATA_W-1:0] ws_d,
                                input logic [CFG_DATA_W-1:0] rows_d,
                                input logic [CFG_DATA_W-1:0] cols_d,
                                input int unsigned mask, input bit spare);
    if (mask[0]) write_reg(CFG_WINDOW, ws_d);
    if (mask[1]) write_reg(CFG_ROWS, rows_d);
    if (mask[2]) write_reg(CFG_COLS, cols_d);
    if (spare) write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_we_i <= 1'b0;
  endtask

  initial begin : receiver
    int unsigned mode;
    int unsigned stretch;
    int unsigned hold_left;
    bit          squeezed;
    glyph_t      got;
    mode      = 0;
    stretch   = 0;
    hold_left = 0;
    squeezed  = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got.symbol    = symbol_o;
        got.level     = level_o;
        got.row_end   = row_end_o;
        got.frame_end = frame_end_o;
        board.check_glyph(got);
      end
      if (squeeze && !squeezed) begin
        squeezed  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        // Hold off long enough for the pipe to back up into the input.
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode    = $urandom_range(0, 2);
          stretch = $urandom_range(5, 120);
        end
        stretch--;
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= ((stretch % 5) < 2);
        endcase
      end
    end
  end

  initial begin : stimulus
    int unsigned           phase;
    int unsigned           fp;
    int unsigned           n;
    logic [CFG_DATA_W-1:0] ws_d;
    logic [CFG_DATA_W-1:0] rows_d;
    logic [CFG_DATA_W-1:0] cols_d;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_WINDOW;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    pixel_value_i <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: one pixel per frame, band edges and the extremes.
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd25);
    send_pixel(8'd26);
    send_pixel(8'd233);
    send_pixel(8'd234);
    in_valid_i <= 1'b0;
    settle();

    // Zero window and zero rows act as 1; columns drop bit 11 and land on 1.
    apply_settings(12'hFFC, 12'h000, 12'h801, 7, 1'b0);
    send_pixel(8'd129);
    send_pixel(8'd130);
    in_valid_i <= 1'b0;
    settle();

    // Window 3 on a 2 x 4 image: partial on the bottom and on the right edge.
    apply_settings(12'h003, 12'h002, 12'h004, 7, 1'b0);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd254);
    send_pixel(8'd7);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd8);
    in_valid_i <= 1'b0;
    settle();

    // Break off a frame with a write to the spare index, then run it whole.
    apply_settings(12'h002, 12'h003, 12'h003, 7, 1'b0);
    send_pixel(8'd200);
    send_pixel(8'd201);
    in_valid_i <= 1'b0;
    settle();
    apply_settings(12'h000, 12'h000, 12'h000, 0, 1'b1);
    repeat (9) send_pixel(PIX_W'($urandom));
    in_valid_i <= 1'b0;
    settle();

    // Tallest frame, left unfinished.
    apply_settings(12'h001, 12'hFFF, 12'h001, 7, 1'b0);
    send_pixel(8'd90);
    send_pixel(8'd180);
    in_valid_i <= 1'b0;
    settle();

    phase = 0;
    while (board.pixels < ITEM_TARGET) begin
      if (phase == 3) begin
        // Widest row; bit 11 of the write is dropped, leaving 1024 columns.
        apply_settings(12'h003, 12'h001, 12'hC00, 7, 1'b0);
        squeeze = 1'b1;
        send_run(MAX_COLS_DEF, 0);
        settle();
      end
      ws_d = CFG_DATA_W'($urandom);
      case ($urandom_range(0, 9))
        0:       rows_d = 12'hFFF;
        1:       rows_d = CFG_DATA_W'($urandom);
        default: rows_d = CFG_DATA_W'($urandom_range(0, 5));
      endcase
      case ($urandom_range(0, 11))
        0:       cols_d = 12'h7FF;
        1:       cols_d = 12'h800 | CFG_DATA_W'($urandom_range(0, 10));
        2:       cols_d = CFG_DATA_W'($urandom);
        default: cols_d = CFG_DATA_W'($urandom_range(0, 10));
      endcase
      apply_settings(ws_d, rows_d, cols_d, $urandom_range(1, 7), ($urandom_range(0, 7) == 0));
      fp = board.frame_pixels();
      if (fp <= 60) begin
        n = fp * $urandom_range(1, 2);
        // Now and then stop partway into a frame.
        if ($urandom_range(0, 3) == 0) n += $urandom_range(0, fp - 1);
      end else begin
        n = $urandom_range(1, 80);
      end
      send_run(n, $urandom_range(0, 2));
      settle();
      phase++;
    end

    $display("run covered %0d pixels, %0d characters, %0d closed frames, %0d register writes, %0d mismatches",
             board.pixels, board.checked, board.frames, board.writes, board.errors);
    $display("band levels seen (9 down to 0): %b; windows 1 to 3 with partial edges, up to %0d columns",
             board.levels_seen, MAX_COLS_DEF);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
